// ===== rtl/cbe_pkg.sv =====
// Shared types, widths and constants for the cubic Bezier easing pipeline.
// No dependencies; imported by every other module in rtl/.
package cbe_pkg;

    // I/O format and internal fixed point
    localparam int FRAC_BITS    = 14;
    localparam int IFRAC        = 30;
    localparam int SCALE_SH     = IFRAC - FRAC_BITS;
    localparam int NEWTON_STEPS = 4;

    // Field widths
    localparam int PROG_W = 15;
    localparam int CY_W   = 16;
    localparam int OUT_W  = 16;
    localparam int IDX_W  = 2;
    localparam int DATA_W = 16;

    // Internal widths (signed unless noted)
    localparam int TQ_W  = 32;   // t, Q2.30
    localparam int TB_W  = 33;   // t or t+h into the evaluator, and 1-t
    localparam int CQ_W  = 32;   // control points, Q.30
    localparam int TU_W  = 34;   // t*(1-t), t*t
    localparam int T3_W  = 36;   // cubic terms
    localparam int TTT_W = 35;   // t^3
    localparam int BT_W  = 37;   // c*cubic term
    localparam int BZ_W  = 39;   // curve value
    localparam int F_W   = 40;   // residual and difference
    localparam int S_W   = 48;   // slope
    localparam int D_W   = 38;   // divisor magnitude (unsigned)
    localparam int FA_W  = 39;   // residual magnitude (unsigned)
    localparam int N_W   = FA_W + 20;  // dividend magnitude (unsigned)
    localparam int QB    = 33;   // quotient bits kept before saturation
    localparam int TN_W  = 36;   // t - q before clamping
    localparam int PW    = 72;   // product width for truncation

    localparam int BEZ_LAT = 4;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_X1 = 2'd0;
    localparam logic [IDX_W-1:0] REG_Y1 = 2'd1;
    localparam logic [IDX_W-1:0] REG_X2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_Y2 = 2'd3;

    localparam logic [PROG_W-1:0] ONE_IO = PROG_W'(1) << FRAC_BITS;

    localparam logic signed [TB_W-1:0] ONE_TB  = TB_W'(1) <<< IFRAC;
    localparam logic signed [TB_W-1:0] STEP_H  = TB_W'(5368709);
    localparam logic [S_W-1:0]         SLOPE_MIN = S_W'(10737418);  // |s|*100 <= 1.0
    localparam logic signed [PW-1:0]   TRUNC_BIAS = (PW'(1) <<< IFRAC) - PW'(1);

    localparam logic signed [TN_W-1:0] TN_MAX = (TN_W'(1) <<< (TQ_W - 1)) - TN_W'(1);
    localparam logic signed [TN_W-1:0] TN_MIN = -(TN_W'(1) <<< (TQ_W - 1));
    localparam logic signed [TQ_W-1:0] TQ_MAX = {1'b0, {(TQ_W - 1){1'b1}}};
    localparam logic signed [TQ_W-1:0] TQ_MIN = {1'b1, {(TQ_W - 1){1'b0}}};

    localparam logic signed [F_W-1:0] ROUND_HALF = F_W'(1) <<< (SCALE_SH - 1);
    localparam logic signed [F_W-1:0] OUT_MAX = F_W'(32767);
    localparam logic signed [F_W-1:0] OUT_MIN = -F_W'(32768);

    // Item state carried down the Newton chain
    typedef struct packed {
        logic                     vld;
        logic                     done;
        logic [PROG_W-1:0]        x;
        logic signed [TQ_W-1:0]   t;
    } cbe_side_t;

    // Product scaled down by 2^30, rounded toward zero
    function automatic logic signed [PW-1:0] qtrunc(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] b;
        b = p[PW-1] ? TRUNC_BIAS : '0;
        return (p + b) >>> IFRAC;
    endfunction

endpackage

// ===== rtl/cbe_bez.sv =====
// Four-stage pipelined evaluator of B(c1,c2,t) = 3c1 t u^2 + 3c2 t^2 u + t^3, u = 1-t.
// Depends on cbe_pkg.
module cbe_bez
    import cbe_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [CQ_W-1:0]  c1,
    input  logic signed [CQ_W-1:0]  c2,
    input  logic signed [TB_W-1:0]  t,
    output logic signed [BZ_W-1:0]  bz
);

    logic signed [TB_W-1:0]        u;
    logic signed [2*TB_W-1:0]      p_tu, p_tt;
    logic signed [TB_W-1:0]        t1_reg, u1_reg;
    logic signed [TU_W-1:0]        tu1_reg, tt1_reg;

    logic signed [TU_W+TB_W-1:0]   p_tuu, p_ttu, p_ttt;
    logic signed [T3_W-1:0]        tuu2_reg, ttu2_reg;
    logic signed [TTT_W-1:0]       ttt2_reg, ttt3_reg;

    logic signed [CQ_W+T3_W-1:0]   p_b1, p_b2;
    logic signed [BT_W-1:0]        b1_3_reg, b2_3_reg;

    logic signed [BZ_W-1:0]        bz_next, bz_reg;

    assign u     = ONE_TB - t;
    assign p_tu  = t * u;
    assign p_tt  = t * t;

    assign p_tuu = tu1_reg * u1_reg;
    assign p_ttu = tu1_reg * t1_reg;
    assign p_ttt = tt1_reg * t1_reg;

    assign p_b1  = c1 * tuu2_reg;
    assign p_b2  = c2 * ttu2_reg;

    assign bz_next = BZ_W'(b1_3_reg) * 3 + BZ_W'(b2_3_reg) * 3 + BZ_W'(ttt3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg   <= t;
            u1_reg   <= u;
            tu1_reg  <= TU_W'(qtrunc(PW'(p_tu)));
            tt1_reg  <= TU_W'(qtrunc(PW'(p_tt)));

            tuu2_reg <= T3_W'(qtrunc(PW'(p_tuu)));
            ttu2_reg <= T3_W'(qtrunc(PW'(p_ttu)));
            ttt2_reg <= TTT_W'(qtrunc(PW'(p_ttt)));

            b1_3_reg <= BT_W'(qtrunc(PW'(p_b1)));
            b2_3_reg <= BT_W'(qtrunc(PW'(p_b2)));
            ttt3_reg <= ttt2_reg;

            bz_reg   <= bz_next;
        end
    end

    assign bz = bz_reg;

endmodule

// ===== rtl/cbe_div.sv =====
// Restoring divider, one quotient bit per pipeline stage, with overflow detect.
// Depends on cbe_pkg.
module cbe_div
    import cbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [N_W-1:0]    num,
    input  logic [D_W-1:0]    den,
    input  logic              neg,
    input  cbe_side_t         side_in,
    output logic [QB-1:0]     quo,
    output logic              ovf,
    output logic              neg_out,
    output cbe_side_t         side_out
);

    logic [D_W-1:0]  r_reg    [QB];
    logic [QB-1:0]   q_reg    [QB];
    logic [QB-1:0]   n_reg    [QB];
    logic [D_W-1:0]  d_reg    [QB];
    logic            neg_reg  [QB];
    logic            ovf_reg  [QB];
    cbe_side_t       side_reg [QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        logic [D_W-1:0]  pr;
        logic [QB-1:0]   pq;
        logic [QB-1:0]   pn;
        logic [D_W-1:0]  pd;
        logic            pneg;
        logic            povf;
        cbe_side_t       pside;
        logic [D_W:0]    r_ext;
        logic            ge;
        logic [D_W:0]    r_sub;

        if (k == 0)
        begin : g_first
            // quotient of 2^QB or more saturates t anyway
            assign pr    = D_W'(num[N_W-1:QB]);
            assign pq    = '0;
            assign pn    = num[QB-1:0];
            assign pd    = den;
            assign pneg  = neg;
            assign povf  = (D_W'(num[N_W-1:QB]) >= den);
            assign pside = side_in;
        end
        else
        begin : g_next
            assign pr    = r_reg[k-1];
            assign pq    = q_reg[k-1];
            assign pn    = n_reg[k-1];
            assign pd    = d_reg[k-1];
            assign pneg  = neg_reg[k-1];
            assign povf  = ovf_reg[k-1];
            assign pside = side_reg[k-1];
        end

        assign r_ext = {pr, pn[QB-1-k]};
        assign ge    = (r_ext >= {1'b0, pd});
        assign r_sub = ge ? (r_ext - {1'b0, pd}) : r_ext;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[k] <= '0;
            end
            else if (en)
            begin
                side_reg[k] <= pside;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]   <= r_sub[D_W-1:0];
                q_reg[k]   <= {pq[QB-2:0], ge};
                n_reg[k]   <= pn;
                d_reg[k]   <= pd;
                neg_reg[k] <= pneg;
                ovf_reg[k] <= povf;
            end
        end
    end

    assign quo      = q_reg[QB-1];
    assign ovf      = ovf_reg[QB-1];
    assign neg_out  = neg_reg[QB-1];
    assign side_out = side_reg[QB-1];

endmodule

// ===== rtl/cbe_newton.sv =====
// One Newton step on Bx(t) = x: forward-difference slope, flat-curve stop,
// pipelined divide and saturating update of t. Depends on cbe_pkg, cbe_bez, cbe_div.
module cbe_newton
    import cbe_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic signed [CQ_W-1:0]  cx1,
    input  logic signed [CQ_W-1:0]  cx2,
    input  cbe_side_t               side_in,
    output cbe_side_t               side_out
);

    logic signed [TB_W-1:0]  t_ext, t_h;
    logic signed [BZ_W-1:0]  bz_t, bz_h;

    cbe_side_t               sd_reg [BEZ_LAT];

    logic signed [F_W-1:0]   x_q;
    logic signed [F_W-1:0]   f_e_reg, diff_e_reg;
    cbe_side_t               se_reg;

    logic signed [F_W-1:0]   f_f_reg;
    logic signed [S_W-1:0]   s_f_reg, s_next;
    cbe_side_t               sf_reg;

    logic [S_W-1:0]          s_abs;
    logic [F_W-1:0]          f_abs;
    cbe_side_t               sg_next, sg_reg;
    logic [N_W-1:0]          num_reg;
    logic [D_W-1:0]          den_reg;
    logic                    neg_reg;

    logic [QB-1:0]           quo;
    logic                    ovf, neg_d;
    cbe_side_t               sdiv;

    logic signed [TN_W-1:0]  q_ext, q_s, t_n;
    logic signed [TQ_W-1:0]  t_upd;
    cbe_side_t               sh_next, sh_reg;

    assign t_ext = TB_W'(side_in.t);
    assign t_h   = t_ext + STEP_H;

    cbe_bez u_bez_t (
        .clk (clk),
        .en  (en),
        .c1  (cx1),
        .c2  (cx2),
        .t   (t_ext),
        .bz  (bz_t)
    );

    cbe_bez u_bez_h (
        .clk (clk),
        .en  (en),
        .c1  (cx1),
        .c2  (cx2),
        .t   (t_h),
        .bz  (bz_h)
    );

    // residual and difference
    assign x_q = F_W'(sd_reg[BEZ_LAT-1].x) << SCALE_SH;

    // slope = diff * 200
    assign s_next = (S_W'(diff_e_reg) <<< 7) + (S_W'(diff_e_reg) <<< 6)
                  + (S_W'(diff_e_reg) <<< 3);

    // magnitudes, stop test, divider operands
    assign s_abs = s_f_reg[S_W-1] ? S_W'(-s_f_reg) : S_W'(s_f_reg);
    assign f_abs = f_f_reg[F_W-1] ? F_W'(-f_f_reg) : F_W'(f_f_reg);

    always_comb
    begin
        sg_next      = sf_reg;
        sg_next.done = sf_reg.done || (s_abs <= SLOPE_MIN);
    end

    cbe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .num      (num_reg),
        .den      (den_reg),
        .neg      (neg_reg),
        .side_in  (sg_reg),
        .quo      (quo),
        .ovf      (ovf),
        .neg_out  (neg_d),
        .side_out (sdiv)
    );

    // t - q, saturated to Q2.30
    assign q_ext = TN_W'(quo);
    assign q_s   = neg_d ? -q_ext : q_ext;
    assign t_n   = TN_W'(sdiv.t) - q_s;

    always_comb
    begin
        if (ovf)
        begin
            t_upd = neg_d ? TQ_MAX : TQ_MIN;
        end
        else if (t_n > TN_MAX)
        begin
            t_upd = TQ_MAX;
        end
        else if (t_n < TN_MIN)
        begin
            t_upd = TQ_MIN;
        end
        else
        begin
            t_upd = TQ_W'(t_n);
        end

        sh_next = sdiv;
        if (!sdiv.done)
        begin
            sh_next.t = t_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BEZ_LAT; i++)
            begin
                sd_reg[i] <= '0;
            end
            se_reg <= '0;
            sf_reg <= '0;
            sg_reg <= '0;
            sh_reg <= '0;
        end
        else if (en)
        begin
            sd_reg[0] <= side_in;
            for (int i = 1; i < BEZ_LAT; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
            se_reg <= sd_reg[BEZ_LAT-1];
            sf_reg <= se_reg;
            sg_reg <= sg_next;
            sh_reg <= sh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_e_reg    <= F_W'(bz_t) - x_q;
            diff_e_reg <= F_W'(bz_h) - F_W'(bz_t);
            f_f_reg    <= f_e_reg;
            s_f_reg    <= s_next;
            num_reg    <= {f_abs[FA_W-1:0], 20'd0};
            den_reg    <= s_abs[D_W+9:10];
            neg_reg    <= f_f_reg[F_W-1] ^ s_f_reg[S_W-1];
        end
    end

    assign side_out = sh_reg;

endmodule

// ===== rtl/cubic_bezier_easing.sv =====
// Cubic Bezier easing: maps progress x (Q1.14) to eased_value y (signed Q1.14)
// on the curve through (0,0) and (1,1) with inner control points from registers
// 0..3 (x1, y1, x2, y2). The block is a fully unrolled pipeline: it takes one item
// every cycle unless stalled, moving it through 170 register stages (input
// register, four Newton steps of 41 stages each, 4 for By(t), output register).
// Most of the depth comes from the per-step divider, which resolves one quotient
// bit per stage. A held out_stall freezes the whole pipeline; in_stall follows it
// when the output register is full. The user must write the control registers only
// while the pipe is empty; the block does not enforce this.
// Depends on cbe_pkg, cbe_newton, cbe_bez.
module cubic_bezier_easing
    import cbe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_index,
    input  logic [DATA_W-1:0]        wr_data,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [PROG_W-1:0]        progress,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [OUT_W-1:0]  eased_value
);

    logic [PROG_W-1:0]        ctrl_x1_reg, ctrl_x2_reg;
    logic signed [CY_W-1:0]   ctrl_y1_reg, ctrl_y2_reg;
    logic signed [CQ_W-1:0]   cx1, cx2, cy1, cy2;

    logic                     en;
    cbe_side_t                side0_next, side0_reg;
    wire cbe_side_t           chain [NEWTON_STEPS+1];

    logic signed [BZ_W-1:0]   bz_y;
    logic                     yv_reg [BEZ_LAT];
    logic signed [F_W-1:0]    y_rnd, y_sh;
    logic signed [OUT_W-1:0]  y_sat;
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  eased_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_x1_reg <= '0;
            ctrl_y1_reg <= '0;
            ctrl_x2_reg <= ONE_IO;
            ctrl_y2_reg <= CY_W'(ONE_IO);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_X1:  ctrl_x1_reg <= wr_data[PROG_W-1:0];
                REG_Y1:  ctrl_y1_reg <= wr_data[CY_W-1:0];
                REG_X2:  ctrl_x2_reg <= wr_data[PROG_W-1:0];
                REG_Y2:  ctrl_y2_reg <= wr_data[CY_W-1:0];
                default: ;
            endcase
        end
    end

    assign cx1 = CQ_W'(ctrl_x1_reg) << SCALE_SH;
    assign cx2 = CQ_W'(ctrl_x2_reg) << SCALE_SH;
    assign cy1 = CQ_W'(ctrl_y1_reg) <<< SCALE_SH;
    assign cy2 = CQ_W'(ctrl_y2_reg) <<< SCALE_SH;

    // whole pipe moves unless a finished item is blocked at the output
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    always_comb
    begin
        side0_next.vld  = in_valid;
        side0_next.done = 1'b0;
        side0_next.x    = progress;
        side0_next.t    = TQ_W'(progress) << SCALE_SH;   // Newton starts at t = x
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side0_reg <= '0;
        end
        else if (en)
        begin
            side0_reg <= side0_next;
        end
    end

    assign chain[0] = side0_reg;

    for (genvar i = 0; i < NEWTON_STEPS; i++)
    begin : g_step
        cbe_newton u_newton (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .cx1      (cx1),
            .cx2      (cx2),
            .side_in  (chain[i]),
            .side_out (chain[i+1])
        );
    end

    cbe_bez u_bez_y (
        .clk (clk),
        .en  (en),
        .c1  (cy1),
        .c2  (cy2),
        .t   (TB_W'(chain[NEWTON_STEPS].t)),
        .bz  (bz_y)
    );

    // round to nearest, ties up, then saturate
    assign y_rnd = F_W'(bz_y) + ROUND_HALF;
    assign y_sh  = y_rnd >>> SCALE_SH;

    always_comb
    begin
        if (y_sh > OUT_MAX)
        begin
            y_sat = OUT_W'(OUT_MAX);
        end
        else if (y_sh < OUT_MIN)
        begin
            y_sat = OUT_W'(OUT_MIN);
        end
        else
        begin
            y_sat = OUT_W'(y_sh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BEZ_LAT; i++)
            begin
                yv_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            yv_reg[0] <= chain[NEWTON_STEPS].vld;
            for (int i = 1; i < BEZ_LAT; i++)
            begin
                yv_reg[i] <= yv_reg[i-1];
            end
            out_valid_reg <= yv_reg[BEZ_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eased_value_reg <= y_sat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign eased_value = eased_value_reg;

endmodule
